// ===== rtl/jtst_pkg.sv =====
// Package with the TAP state type, state codes and transition functions of the tracker.
`default_nettype none

package jtst_pkg;

	localparam int unsigned CODE_W = 5;
	localparam int unsigned SYNC_W = 4;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [SYNC_W-1:0] sync_len_t;

	localparam sync_len_t SYNC_LENGTH_RESET = 4'd5;
	localparam sync_len_t SYNC_COUNT_MAX    = 4'd15;

	// One-hot controller state; the unknown state is its own hot bit.
	typedef enum logic [16:0] {
		ST_RESET      = 17'h00001,
		ST_IDLE       = 17'h00002,
		ST_DR_SELECT  = 17'h00004,
		ST_DR_CAPTURE = 17'h00008,
		ST_DR_SHIFT   = 17'h00010,
		ST_DR_EXIT1   = 17'h00020,
		ST_DR_PAUSE   = 17'h00040,
		ST_DR_EXIT2   = 17'h00080,
		ST_DR_UPDATE  = 17'h00100,
		ST_IR_SELECT  = 17'h00200,
		ST_IR_CAPTURE = 17'h00400,
		ST_IR_SHIFT   = 17'h00800,
		ST_IR_EXIT1   = 17'h01000,
		ST_IR_PAUSE   = 17'h02000,
		ST_IR_EXIT2   = 17'h04000,
		ST_IR_UPDATE  = 17'h08000,
		ST_UNKNOWN    = 17'h10000
	} tap_state_t;

	localparam code_t CODE_RESET      = 5'd0;
	localparam code_t CODE_IDLE       = 5'd1;
	localparam code_t CODE_DR_SELECT  = 5'd2;
	localparam code_t CODE_DR_CAPTURE = 5'd3;
	localparam code_t CODE_DR_SHIFT   = 5'd4;
	localparam code_t CODE_DR_EXIT1   = 5'd5;
	localparam code_t CODE_DR_PAUSE   = 5'd6;
	localparam code_t CODE_DR_EXIT2   = 5'd7;
	localparam code_t CODE_DR_UPDATE  = 5'd8;
	localparam code_t CODE_IR_SELECT  = 5'd9;
	localparam code_t CODE_IR_CAPTURE = 5'd10;
	localparam code_t CODE_IR_SHIFT   = 5'd11;
	localparam code_t CODE_IR_EXIT1   = 5'd12;
	localparam code_t CODE_IR_PAUSE   = 5'd13;
	localparam code_t CODE_IR_EXIT2   = 5'd14;
	localparam code_t CODE_IR_UPDATE  = 5'd15;
	localparam code_t CODE_UNKNOWN    = 5'd16;

	function automatic code_t tap_code(input tap_state_t st);
		code_t c;
		unique case (st)
			ST_RESET:      c = CODE_RESET;
			ST_IDLE:       c = CODE_IDLE;
			ST_DR_SELECT:  c = CODE_DR_SELECT;
			ST_DR_CAPTURE: c = CODE_DR_CAPTURE;
			ST_DR_SHIFT:   c = CODE_DR_SHIFT;
			ST_DR_EXIT1:   c = CODE_DR_EXIT1;
			ST_DR_PAUSE:   c = CODE_DR_PAUSE;
			ST_DR_EXIT2:   c = CODE_DR_EXIT2;
			ST_DR_UPDATE:  c = CODE_DR_UPDATE;
			ST_IR_SELECT:  c = CODE_IR_SELECT;
			ST_IR_CAPTURE: c = CODE_IR_CAPTURE;
			ST_IR_SHIFT:   c = CODE_IR_SHIFT;
			ST_IR_EXIT1:   c = CODE_IR_EXIT1;
			ST_IR_PAUSE:   c = CODE_IR_PAUSE;
			ST_IR_EXIT2:   c = CODE_IR_EXIT2;
			ST_IR_UPDATE:  c = CODE_IR_UPDATE;
			default:       c = CODE_UNKNOWN;
		endcase
		return c;
	endfunction

	// Standard TAP transition graph for the sixteen known states.
	function automatic tap_state_t tap_next(input tap_state_t st, input logic tms);
		tap_state_t n;
		unique case (st)
			ST_RESET:      n = tms ? ST_RESET      : ST_IDLE;
			ST_IDLE:       n = tms ? ST_DR_SELECT  : ST_IDLE;
			ST_DR_SELECT:  n = tms ? ST_IR_SELECT  : ST_DR_CAPTURE;
			ST_DR_CAPTURE: n = tms ? ST_DR_EXIT1   : ST_DR_SHIFT;
			ST_DR_SHIFT:   n = tms ? ST_DR_EXIT1   : ST_DR_SHIFT;
			ST_DR_EXIT1:   n = tms ? ST_DR_UPDATE  : ST_DR_PAUSE;
			ST_DR_PAUSE:   n = tms ? ST_DR_EXIT2   : ST_DR_PAUSE;
			ST_DR_EXIT2:   n = tms ? ST_DR_UPDATE  : ST_DR_SHIFT;
			ST_DR_UPDATE:  n = tms ? ST_DR_SELECT  : ST_IDLE;
			ST_IR_SELECT:  n = tms ? ST_RESET      : ST_IR_CAPTURE;
			ST_IR_CAPTURE: n = tms ? ST_IR_EXIT1   : ST_IR_SHIFT;
			ST_IR_SHIFT:   n = tms ? ST_IR_EXIT1   : ST_IR_SHIFT;
			ST_IR_EXIT1:   n = tms ? ST_IR_UPDATE  : ST_IR_PAUSE;
			ST_IR_PAUSE:   n = tms ? ST_IR_EXIT2   : ST_IR_PAUSE;
			ST_IR_EXIT2:   n = tms ? ST_IR_UPDATE  : ST_IR_SHIFT;
			ST_IR_UPDATE:  n = tms ? ST_DR_SELECT  : ST_IDLE;
			default:       n = ST_UNKNOWN;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/jtst_if.sv =====
// Channel interfaces of the tracker: TMS requests, state results and configuration writes.
`default_nettype none

interface jtst_in_if;
	logic valid;
	logic ready;
	logic tms;

	modport source (output valid, output tms, input ready);
	modport sink (input valid, input tms, output ready);
endinterface

interface jtst_out_if;
	logic               valid;
	logic               ready;
	jtst_pkg::code_t    tap_state;
	jtst_pkg::code_t    prior_state;

	modport source (output valid, output tap_state, output prior_state, input ready);
	modport sink (input valid, input tap_state, input prior_state, output ready);
endinterface

interface jtst_cfg_if;
	logic                 valid;
	logic                 ready;
	jtst_pkg::sync_len_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/jtag_tap_state_tracker.sv =====
// Top level of the JTAG TAP state tracker.
//
// Each request on in_ch carries one TMS bit sampled on a test clock tick. For every
// request one result leaves on out_ch: tap_state is the controller state after the
// tick and prior_state the state before it (0 reset, 1 idle, 2-8 DR path, 9-15 IR
// path, 16 unknown). The cfg channel writes sync_length, the number of consecutive
// TMS highs that bring the unknown state to Test-Logic-Reset; it is always ready
// and should only be written while no request is in flight.
// A request's result is registered and shows on out_ch in the cycle after it is accepted.
// Throughput is one request per cycle while out_ch is ready; the next state is worked
// out in the same cycle from the state register and the TMS bit, into the result register.
// in_ch is ready whenever the result register is empty or being drained, so a
// stalled receiver holds one result and stops new requests until it takes it.
// Reset (arst_n low) puts the tracker in the unknown state with a zero run count,
// sync_length back to 5 and the result register empty.
`default_nettype none

module jtag_tap_state_tracker import jtst_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	jtst_in_if.sink      in_ch,
	jtst_out_if.source   out_ch,
	jtst_cfg_if.sink     cfg
);

	tap_state_t cur_q;
	tap_state_t cur_next;
	sync_len_t  sync_len_q;
	sync_len_t  run_cnt_q;
	sync_len_t  run_cnt_next;
	logic       out_valid_q;
	code_t      tap_state_q;
	code_t      prior_state_q;
	logic       in_accept;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_accept   = in_ch.valid && in_ch.ready;
	assign cfg.ready   = 1'b1;

	always_comb begin
		cur_next     = tap_next(cur_q, in_ch.tms);
		run_cnt_next = run_cnt_q;
		if (cur_q == ST_UNKNOWN) begin
			if (in_ch.tms) begin
				if (run_cnt_q != SYNC_COUNT_MAX) begin
					run_cnt_next = run_cnt_q + 4'd1;
				end
				cur_next = (run_cnt_next >= sync_len_q) ? ST_RESET : ST_UNKNOWN;
			end else begin
				run_cnt_next = '0;
				cur_next     = ST_UNKNOWN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= ST_UNKNOWN;
			run_cnt_q   <= '0;
			sync_len_q  <= SYNC_LENGTH_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				sync_len_q <= cfg.data;
			end
			if (in_accept) begin
				cur_q       <= cur_next;
				run_cnt_q   <= run_cnt_next;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			tap_state_q   <= tap_code(cur_next);
			prior_state_q <= tap_code(cur_q);
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.tap_state   = tap_state_q;
	assign out_ch.prior_state = prior_state_q;

	// Once synchronized, the tracker never goes back to the unknown state.
	a_no_return_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q != ST_UNKNOWN |=> cur_q != ST_UNKNOWN)
		else $error("tracker fell back to the unknown state");

	// A low TMS while unknown keeps the tracker unknown.
	a_low_stays_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && cur_q == ST_UNKNOWN && !in_ch.tms |=> cur_q == ST_UNKNOWN)
		else $error("left the unknown state on a low TMS");

	// The held result always reports the state the tracker is in.
	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> tap_state_q == tap_code(cur_q))
		else $error("result state differs from the state register");

	// Every accepted request leaves a result behind.
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> out_valid_q)
		else $error("accepted request produced no result");

endmodule

`default_nettype wire

// ===== tb/jtag_tap_state_tracker_tb.sv =====
// Self-checking testbench of the JTAG TAP state tracker: TMS sync, TAP walks and stalls.
`timescale 1ns / 100ps

module jtag_tap_state_tracker_tb;
	import jtst_pkg::*;

	typedef struct packed {
		code_t tap_state;
		code_t prior_state;
	} tap_result_t;

	logic clk;
	logic arst_n;

	jtst_in_if  in_ch();
	jtst_out_if out_ch();
	jtst_cfg_if cfg_ch();

	jtag_tap_state_tracker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_ch)
	);

	bit          tms_pending[$];
	tap_result_t pending_results[$];

	int src_idle_pct = 28;
	int snk_idle_pct = 71;
	int err_count = 0;
	int queued_total = 0;
	int results_checked = 0;
	int sync_writes = 0;
	bit in_taken = 1'b0;
	bit hold_req = 1'b0;
	bit hold_armed = 1'b0;
	int hold_left = 0;
	logic [16:0] seen_states = '0;

	// Tracker state as the testbench sees it.
	code_t     trk_state;
	sync_len_t trk_sync_len;
	sync_len_t trk_high_run;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Standard TAP transitions for the sixteen synchronized states.
	function automatic code_t tap_follow(input code_t st, input bit tms);
		code_t nxt;
		case (st)
			CODE_RESET:      nxt = tms ? CODE_RESET     : CODE_IDLE;
			CODE_IDLE:       nxt = tms ? CODE_DR_SELECT : CODE_IDLE;
			CODE_DR_SELECT:  nxt = tms ? CODE_IR_SELECT : CODE_DR_CAPTURE;
			CODE_DR_CAPTURE: nxt = tms ? CODE_DR_EXIT1  : CODE_DR_SHIFT;
			CODE_DR_SHIFT:   nxt = tms ? CODE_DR_EXIT1  : CODE_DR_SHIFT;
			CODE_DR_EXIT1:   nxt = tms ? CODE_DR_UPDATE : CODE_DR_PAUSE;
			CODE_DR_PAUSE:   nxt = tms ? CODE_DR_EXIT2  : CODE_DR_PAUSE;
			CODE_DR_EXIT2:   nxt = tms ? CODE_DR_UPDATE : CODE_DR_SHIFT;
			CODE_DR_UPDATE:  nxt = tms ? CODE_DR_SELECT : CODE_IDLE;
			CODE_IR_SELECT:  nxt = tms ? CODE_RESET     : CODE_IR_CAPTURE;
			CODE_IR_CAPTURE: nxt = tms ? CODE_IR_EXIT1  : CODE_IR_SHIFT;
			CODE_IR_SHIFT:   nxt = tms ? CODE_IR_EXIT1  : CODE_IR_SHIFT;
			CODE_IR_EXIT1:   nxt = tms ? CODE_IR_UPDATE : CODE_IR_PAUSE;
			CODE_IR_PAUSE:   nxt = tms ? CODE_IR_EXIT2  : CODE_IR_PAUSE;
			CODE_IR_EXIT2:   nxt = tms ? CODE_IR_UPDATE : CODE_IR_SHIFT;
			CODE_IR_UPDATE:  nxt = tms ? CODE_DR_SELECT : CODE_IDLE;
			default:         nxt = CODE_UNKNOWN;
		endcase
		return nxt;
	endfunction

	// Prediction on accepted requests and checking of accepted results.
	always @(posedge clk) begin : track_states
		tap_result_t want;
		tap_result_t got;
		code_t nxt;
		if (!arst_n) begin
			trk_state = CODE_UNKNOWN;
			trk_sync_len = SYNC_LENGTH_RESET;
			trk_high_run = '0;
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_ch.valid && in_ch.ready;
			if (cfg_ch.valid && cfg_ch.ready)
				trk_sync_len = cfg_ch.data;
			if (in_ch.valid && in_ch.ready) begin
				if (trk_state < CODE_UNKNOWN) begin
					nxt = tap_follow(trk_state, in_ch.tms);
				end else if (in_ch.tms) begin
					// The run of highs saturates rather than wrapping.
					if (trk_high_run < SYNC_COUNT_MAX)
						trk_high_run = trk_high_run + 1'b1;
					nxt = (trk_high_run >= trk_sync_len) ? CODE_RESET : CODE_UNKNOWN;
				end else begin
					trk_high_run = '0;
					nxt = CODE_UNKNOWN;
				end
				want.tap_state = nxt;
				want.prior_state = trk_state;
				trk_state = nxt;
				pending_results.push_back(want);
			end
			if (out_ch.valid && out_ch.ready) begin
				got.tap_state = out_ch.tap_state;
				got.prior_state = out_ch.prior_state;
				if (pending_results.size() == 0) begin
					$error("result with no request outstanding: tap_state %0d prior_state %0d",
						got.tap_state, got.prior_state);
					err_count++;
				end else begin
					want = pending_results.pop_front();
					if (got.tap_state !== want.tap_state) begin
						$error("tap_state expected %0d actual %0d",
							want.tap_state, got.tap_state);
						err_count++;
					end
					if (got.prior_state !== want.prior_state) begin
						$error("prior_state expected %0d actual %0d",
							want.prior_state, got.prior_state);
						err_count++;
					end
					if (got.tap_state <= CODE_UNKNOWN)
						seen_states[got.tap_state] = 1'b1;
					results_checked++;
				end
			end
		end
	end

	// TMS request driver: holds an offer until it is taken.
	always @(negedge clk) begin : drive_tms
		bit nv;
		bit nt;
		nv = in_ch.valid;
		nt = in_ch.tms;
		if (!arst_n) begin
			nv = 1'b0;
		end else if (!in_ch.valid || in_taken) begin
			if (tms_pending.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
				nt = tms_pending.pop_front();
				nv = 1'b1;
			end else begin
				nv = 1'b0;
			end
		end
		in_ch.valid <= nv;
		in_ch.tms <= nt;
	end

	// Result receiver, with one long hold-off when asked for.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else if (hold_req && !hold_armed) begin
			hold_armed <= 1'b1;
			hold_left <= 80;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	task automatic push_tms(input bit b);
		tms_pending.push_back(b);
		queued_total++;
	endtask

	// A DR or IR scan with random shift and pause lengths.
	task automatic queue_scan();
		if ($urandom_range(0, 3) == 0) begin
			repeat (5) push_tms(1'b1);
			push_tms(1'b0);
		end
		push_tms(1'b1);
		if ($urandom_range(0, 1))
			push_tms(1'b1);
		push_tms(1'b0);
		repeat ($urandom_range(0, 10)) push_tms(1'b0);
		push_tms(1'b1);
		if ($urandom_range(0, 2) == 0) begin
			repeat ($urandom_range(1, 6)) push_tms(1'b0);
			push_tms(1'b1);
			if ($urandom_range(0, 1)) begin
				// Back from exit2 into shift, then out through exit1.
				repeat ($urandom_range(1, 4)) push_tms(1'b0);
				push_tms(1'b1);
			end
		end
		push_tms(1'b1);
		if ($urandom_range(0, 1))
			repeat ($urandom_range(1, 3)) push_tms(1'b0);
	endtask

	task automatic queue_noise();
		int bias;
		bias = $urandom_range(10, 90);
		repeat ($urandom_range(1, 16)) push_tms($urandom_range(0, 99) < bias);
	endtask

	task automatic run_random(input int count);
		int start;
		start = queued_total;
		while (queued_total - start < count) begin
			if ($urandom_range(0, 9) < 7)
				queue_scan();
			else
				queue_noise();
			while (tms_pending.size() > 16) @(negedge clk);
		end
	endtask

	// Checked at the rising edge, where the driver's offer has settled.
	task automatic wait_idle();
		@(posedge clk);
		while (tms_pending.size() != 0 || in_ch.valid || pending_results.size() != 0)
			@(posedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_sync_len(input sync_len_t len);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= len;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		sync_writes++;
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.tms = 1'b0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = SYNC_LENGTH_RESET;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// With the default length of five, four highs fall short and a low clears them.
		repeat (4) push_tms(1'b1);
		push_tms(1'b0);
		wait_idle();
		write_sync_len(4'd15);
		repeat (14) push_tms(1'b1);
		push_tms(1'b0);
		wait_idle();
		// A zero length: a low still stays unknown, the first high synchronizes.
		write_sync_len(4'd0);
		push_tms(1'b0);
		push_tms(1'b1);
		push_tms(1'b1);
		push_tms(1'b0);
		wait_idle();

		write_sync_len(sync_len_t'($urandom_range(1, 14)));
		run_random(250);
		wait_idle();

		src_idle_pct = 71;
		snk_idle_pct = 28;
		write_sync_len(4'd15);
		run_random(125);
		// The sender pauses here until every result has come back.
		wait_idle();
		run_random(125);
		wait_idle();

		src_idle_pct = 0;
		snk_idle_pct = 0;
		write_sync_len(4'd1);
		hold_req = 1'b1;
		run_random(250);
		wait_idle();
		repeat (4) @(negedge clk);

		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			err_count++;
		end
		$display("summary: %0d TMS requests, %0d results checked, %0d sync_length writes",
			queued_total, results_checked, sync_writes);
		$display("summary: %0d of 17 state codes reached, %0d errors",
			$countones(seen_states), err_count);
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/jtst_pkg.sv
rtl/jtst_if.sv
rtl/jtag_tap_state_tracker.sv
tb/jtag_tap_state_tracker_tb.sv
